// ===== rtl/core/dxf_group_code_tokenizer_assert.svh =====
// Assertion macros shared by the tokenizer modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DXF_GROUP_CODE_TOKENIZER_ASSERT_SVH
`define DXF_GROUP_CODE_TOKENIZER_ASSERT_SVH

// Same-cycle implication
`define DXFGCT_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication
`define DXFGCT_ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/core/dxfgct_pkg.sv =====
`timescale 1ns / 1ps
package dxfgct_pkg;

    // Field widths
    localparam int TEXT_W  = 8;
    localparam int CFG_W   = 9;
    localparam int TAG_W   = 6;
    localparam int VTYPE_W = 2;
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;

    // Line length ceiling and counter width
    localparam int MAX_LINE = 256;
    localparam int CNT_W    = $clog2(MAX_LINE + 1);
    localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(256);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result kinds
    localparam logic [KIND_W-1:0] RK_TEXT  = 2'd0;
    localparam logic [KIND_W-1:0] RK_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] RK_ERROR = 2'd2;

    // Value types
    localparam logic [VTYPE_W-1:0] VT_STRING = 2'd0;
    localparam logic [VTYPE_W-1:0] VT_FLOAT  = 2'd1;
    localparam logic [VTYPE_W-1:0] VT_INT    = 2'd2;
    localparam logic [VTYPE_W-1:0] VT_BINARY = 2'd3;

    localparam logic [TAG_W-1:0] TAG_INVALID = 6'd61;

    // Group-code range table, first match wins
    localparam int NRANGES = 61;
    localparam int CODE_W  = 11;

    localparam logic [CODE_W-1:0] RANGE_LO [NRANGES] = '{
        0, 1, 2, 3, 5, 6, 7, 8, 9, 10, 20, 30, 38, 39, 40, 49, 50, 60, 62, 66,
        67, 70, 90, 100, 102, 105, 210, 220, 230, 280, 300, 310, 320, 330, 340,
        350, 360, 999, 1000, 1001, 1002, 1003, 1004, 1005, 1010, 1020, 1030,
        1011, 1021, 1031, 1012, 1022, 1032, 1013, 1023, 1033, 1040, 1041, 1042,
        1070, 1071
    };
    localparam logic [CODE_W-1:0] RANGE_HI [NRANGES] = '{
        0, 1, 2, 4, 5, 6, 7, 8, 9, 18, 28, 37, 38, 39, 48, 49, 58, 60, 62, 66,
        67, 78, 99, 100, 102, 105, 210, 220, 230, 289, 309, 319, 329, 339, 349,
        359, 369, 999, 1000, 1001, 1002, 1003, 1004, 1005, 1010, 1020, 1030,
        1011, 1021, 1031, 1012, 1022, 1032, 1013, 1023, 1033, 1040, 1041, 1042,
        1070, 1071
    };
    localparam logic [VTYPE_W-1:0] RANGE_TYPE [NRANGES] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 1, 1, 1, 2, 2, 2,
        2, 2, 2, 0, 0, 0, 1, 1, 1, 2, 0, 3, 0, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 3, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 2, 2
    };

    // Number parser phases
    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_HEX,
        PH_DIGITS,
        PH_DONE
    } dxfgct_phase_t;

    typedef enum logic [1:0] {
        BASE_8,
        BASE_10,
        BASE_16
    } dxfgct_base_t;

    // One classified byte event, front to back
    typedef struct packed {
        logic [TEXT_W-1:0]  text;
        logic               char_val;
        logic               line_end;
        logic               end_code;
        logic               eod_err;
        logic               eod;
        logic [VALUE_W-1:0] value;
    } dxfgct_rec_t;

    // One result transaction
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TAG_W-1:0]   tag;
        logic [VTYPE_W-1:0] vtype;
        logic [TEXT_W-1:0]  text;
        logic [VALUE_W-1:0] ival;
        logic               last;
    } dxfgct_res_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [VTYPE_W-1:0] vtype;
    } dxfgct_class_t;

    // Look up a group code in the range table
    function automatic dxfgct_class_t dxfgct_classify(input logic [VALUE_W-1:0] code);
        dxfgct_class_t r;
        r.tag   = TAG_INVALID;
        r.vtype = VT_STRING;
        if (code[VALUE_W-1:CODE_W] == '0) begin
            for (int i = NRANGES - 1; i >= 0; i--) begin
                if (code[CODE_W-1:0] >= RANGE_LO[i] && code[CODE_W-1:0] <= RANGE_HI[i]) begin
                    r.tag   = TAG_W'(i);
                    r.vtype = RANGE_TYPE[i];
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/dxfgct_in_if.sv =====
`timescale 1ns / 1ps
interface dxfgct_in_if;
    import dxfgct_pkg::*;

    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_byte_in;
    logic              end_of_data;

    modport source (output valid, output text_byte_in, output end_of_data, input ready);
    modport sink (input valid, input text_byte_in, input end_of_data, output ready);
endinterface

// ===== rtl/core/dxfgct_cfg_if.sv =====
`timescale 1ns / 1ps
interface dxfgct_cfg_if;
    import dxfgct_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] line_limit;

    modport source (output valid, output line_limit, input ready);
    modport sink (input valid, input line_limit, output ready);
endinterface

// ===== rtl/core/dxfgct_out_if.sv =====
`timescale 1ns / 1ps
interface dxfgct_out_if;
    import dxfgct_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         result_kind;
    logic [TAG_W-1:0]          tag_index;
    logic [VTYPE_W-1:0]        value_type;
    logic [TEXT_W-1:0]         text_byte_out;
    logic signed [VALUE_W-1:0] int_value;
    logic                      last;

    modport source (
        output valid, output result_kind, output tag_index, output value_type,
        output text_byte_out, output int_value, output last, input ready
    );
    modport sink (
        input valid, input result_kind, input tag_index, input value_type,
        input text_byte_out, input int_value, input last, output ready
    );
endinterface

// ===== rtl/core/dxfgct_queue.sv =====
`timescale 1ns / 1ps
`include "dxf_group_code_tokenizer_assert.svh"
module dxfgct_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dxfgct_pkg::dxfgct_rec_t push_rec,
    output logic                  full,
    input  logic                  pop,
    output logic                  pop_valid,
    output dxfgct_pkg::dxfgct_rec_t pop_rec
);
    import dxfgct_pkg::*;

    dxfgct_rec_t       entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_rec   = entries_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed records
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_rec;
        end
    end

    `DXFGCT_ASSERT_IMP(a_q_count_range, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
    `DXFGCT_ASSERT_IMP(a_q_no_overflow, full, !push, "push into full queue")
    `DXFGCT_ASSERT_IMP(a_q_no_underflow, pop, pop_valid, "pop from empty queue")

endmodule

// ===== rtl/core/dxfgct_front.sv =====
`timescale 1ns / 1ps
module dxfgct_front (
    input  logic                    clk,
    input  logic                    rst_n,
    dxfgct_in_if.sink               text,
    dxfgct_cfg_if.sink              cfg,
    input  logic                    queue_full,
    output logic                    rec_push,
    output dxfgct_pkg::dxfgct_rec_t rec
);
    import dxfgct_pkg::*;

    localparam logic [TEXT_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [TEXT_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [TEXT_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [TEXT_W-1:0] CHAR_VT    = 8'h0B;
    localparam logic [TEXT_W-1:0] CHAR_FF    = 8'h0C;
    localparam logic [TEXT_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [TEXT_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [TEXT_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [TEXT_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [TEXT_W-1:0] CHAR_0     = 8'h30;
    localparam logic [TEXT_W-1:0] CHAR_1     = 8'h31;
    localparam logic [TEXT_W-1:0] CHAR_9     = 8'h39;
    localparam logic [TEXT_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [TEXT_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [TEXT_W-1:0] CHAR_UX    = 8'h58;
    localparam logic [TEXT_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [TEXT_W-1:0] CHAR_LF_HEX = 8'h66;
    localparam logic [TEXT_W-1:0] CHAR_LX    = 8'h78;

    logic [CFG_W-1:0]   line_limit_reg;
    logic               on_value_line_reg;
    logic               on_value_line_next;
    logic               pending_cr_reg;
    logic               pending_cr_next;
    dxfgct_phase_t      phase_reg;
    dxfgct_phase_t      phase_next;
    dxfgct_base_t       base_reg;
    dxfgct_base_t       base_next;
    logic               neg_reg;
    logic               neg_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [CNT_W-1:0]   chars_reg;
    logic [CNT_W-1:0]   chars_next;
    logic               stream_dead_reg;
    logic               stream_dead_next;

    logic [TEXT_W-1:0]  c;
    logic               eod;
    logic               accept;
    logic               swallow;
    logic               is_term;
    logic               is_plain;
    logic [CMP_W-1:0]   limit_eff;
    logic               taken;
    logic               line_end;
    logic               ovl_after;
    logic               char_val;
    logic               blank;
    logic               dig_ok;
    logic [3:0]         dig;
    logic               dig_fits;
    logic [VALUE_W-1:0] dig_ext;
    logic [VALUE_W-1:0] first_val;
    logic [VALUE_W-1:0] scaled;
    dxfgct_phase_t      ph_step;
    dxfgct_base_t       base_step;
    logic               neg_step;
    logic [VALUE_W-1:0] val_step;

    assign cfg.ready  = 1'b1;
    assign text.ready = !queue_full;
    assign accept     = text.valid && text.ready;
    assign c          = text.text_byte_in;
    assign eod        = text.end_of_data;

    // Line terminators, with LF after CR swallowed
    assign swallow  = pending_cr_reg && (c == CHAR_LF);
    assign is_term  = !swallow && ((c == CHAR_CR) || (c == CHAR_LF));
    assign is_plain = !swallow && !is_term;

    // Apply the line limit, capped at the line ceiling
    assign limit_eff = (CMP_W'(line_limit_reg) > CMP_W'(MAX_LINE))
                       ? CMP_W'(MAX_LINE) : CMP_W'(line_limit_reg);
    assign taken     = is_plain && (CMP_W'(chars_reg) < limit_eff);
    assign line_end  = is_term || (is_plain && eod);
    assign ovl_after = line_end ? !on_value_line_reg : on_value_line_reg;
    assign char_val  = taken && on_value_line_reg && !stream_dead_reg && (c != CHAR_NUL);

    // Decode the character as a digit
    always_comb
    begin
        dig_ok = 1'b1;
        dig    = '0;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            dig = 4'(c - CHAR_0);
        end
        else if (c >= CHAR_LA && c <= CHAR_LF_HEX)
        begin
            dig = 4'(c - CHAR_LA + 8'd10);
        end
        else if (c >= CHAR_UA && c <= CHAR_UF)
        begin
            dig = 4'(c - CHAR_UA + 8'd10);
        end
        else
        begin
            dig_ok = 1'b0;
        end
    end

    assign blank   = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    assign dig_ext = VALUE_W'(dig);

    // First digit carries the sign; later ones accumulate toward it
    assign first_val = neg_reg ? (VALUE_W'(0) - dig_ext) : dig_ext;

    always_comb
    begin
        unique case (base_reg)
            BASE_8:
            begin
                scaled   = value_reg << 3;
                dig_fits = dig_ok && (dig < 4'd8);
            end
            BASE_16:
            begin
                scaled   = value_reg << 4;
                dig_fits = dig_ok;
            end
            default:
            begin
                scaled   = (value_reg << 3) + (value_reg << 1);
                dig_fits = dig_ok && (dig < 4'd10);
            end
        endcase
    end

    // Step the number parser by one character
    always_comb
    begin
        ph_step   = phase_reg;
        base_step = base_reg;
        neg_step  = neg_reg;
        val_step  = value_reg;
        priority if (phase_reg == PH_DONE || c == CHAR_NUL)
        begin
            ph_step = PH_DONE;
        end
        else if (phase_reg == PH_START && blank)
        begin
            ph_step = PH_START;
        end
        else if (phase_reg == PH_START && (c == CHAR_PLUS || c == CHAR_MINUS))
        begin
            neg_step = (c == CHAR_MINUS);
            ph_step  = PH_SIGN;
        end
        else if (phase_reg == PH_START || phase_reg == PH_SIGN)
        begin
            if (c == CHAR_0)
            begin
                ph_step   = PH_ZERO;
                base_step = BASE_8;
                val_step  = '0;
            end
            else if (c >= CHAR_1 && c <= CHAR_9)
            begin
                ph_step   = PH_DIGITS;
                base_step = BASE_10;
                val_step  = first_val;
            end
            else
            begin
                ph_step = PH_DONE;
            end
        end
        else if (phase_reg == PH_ZERO)
        begin
            if (c == CHAR_LX || c == CHAR_UX)
            begin
                ph_step   = PH_HEX;
                base_step = BASE_16;
            end
            else if (dig_ok && dig < 4'd8)
            begin
                ph_step  = PH_DIGITS;
                val_step = first_val;
            end
            else
            begin
                ph_step = PH_DONE;
            end
        end
        else if (phase_reg == PH_HEX)
        begin
            if (dig_ok)
            begin
                ph_step  = PH_DIGITS;
                val_step = first_val;
            end
            else
            begin
                ph_step = PH_DONE;
            end
        end
        else
        begin
            if (dig_fits)
            begin
                val_step = neg_reg ? (scaled - dig_ext) : (scaled + dig_ext);
            end
            else
            begin
                ph_step = PH_DONE;
            end
        end
    end

    // Build the event record for the back end
    always_comb
    begin
        rec.text     = c;
        rec.char_val = char_val;
        rec.line_end = line_end;
        rec.end_code = !on_value_line_reg;
        rec.eod_err  = eod && ovl_after;
        rec.eod      = eod;
        rec.value    = taken ? val_step : value_reg;
    end

    assign rec_push = accept && (char_val || line_end || eod);

    // Next line and parser state
    always_comb
    begin
        on_value_line_next = on_value_line_reg;
        pending_cr_next    = pending_cr_reg;
        phase_next         = phase_reg;
        base_next          = base_reg;
        neg_next           = neg_reg;
        value_next         = value_reg;
        chars_next         = chars_reg;
        stream_dead_next   = stream_dead_reg;
        if (accept)
        begin
            pending_cr_next = is_term && (c == CHAR_CR);
            if (taken)
            begin
                chars_next       = chars_reg + 1'b1;
                phase_next       = ph_step;
                base_next        = base_step;
                neg_next         = neg_step;
                value_next       = val_step;
                stream_dead_next = stream_dead_reg
                                   || (on_value_line_reg && (c == CHAR_NUL));
            end
            if (line_end || eod)
            begin
                phase_next       = PH_START;
                base_next        = BASE_10;
                neg_next         = 1'b0;
                value_next       = '0;
                chars_next       = '0;
                stream_dead_next = 1'b0;
            end
            if (line_end)
            begin
                on_value_line_next = !on_value_line_reg;
            end
            if (eod)
            begin
                on_value_line_next = 1'b0;
                pending_cr_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg    <= LIMIT_RESET;
            on_value_line_reg <= 1'b0;
            pending_cr_reg    <= 1'b0;
            phase_reg         <= PH_START;
            base_reg          <= BASE_10;
            neg_reg           <= 1'b0;
            value_reg         <= '0;
            chars_reg         <= '0;
            stream_dead_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                line_limit_reg <= cfg.line_limit;
            end
            on_value_line_reg <= on_value_line_next;
            pending_cr_reg    <= pending_cr_next;
            phase_reg         <= phase_next;
            base_reg          <= base_next;
            neg_reg           <= neg_next;
            value_reg         <= value_next;
            chars_reg         <= chars_next;
            stream_dead_reg   <= stream_dead_next;
        end
    end

endmodule

// ===== rtl/core/dxfgct_back.sv =====
`timescale 1ns / 1ps
`include "dxf_group_code_tokenizer_assert.svh"
module dxfgct_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rec_valid,
    input  dxfgct_pkg::dxfgct_rec_t rec,
    output logic                    rec_pop,
    dxfgct_out_if.source            result
);
    import dxfgct_pkg::*;

    logic               out_valid_reg;
    logic               out_valid_next;
    dxfgct_res_t        out_reg;
    dxfgct_res_t        out_next;
    logic               spill_valid_reg;
    logic               spill_valid_next;
    dxfgct_res_t        spill_reg;
    dxfgct_res_t        spill_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;
    logic [VTYPE_W-1:0] vtype_reg;
    logic [VTYPE_W-1:0] vtype_next;

    dxfgct_class_t      cls;
    logic               do_cls;
    logic [TAG_W-1:0]   tag_eff;
    logic [VTYPE_W-1:0] vtype_eff;
    logic               has_text;
    logic               has_done;
    logic               has_err;
    logic               first_valid;
    logic               second_valid;
    dxfgct_res_t        text_res;
    dxfgct_res_t        done_res;
    dxfgct_res_t        err_res;
    dxfgct_res_t        first_res;
    logic               out_free;

    // Classify a finished code line
    assign cls       = dxfgct_classify(rec.value);
    assign do_cls    = rec.line_end && rec.end_code;
    assign tag_eff   = do_cls ? cls.tag : tag_reg;
    assign vtype_eff = do_cls ? cls.vtype : vtype_reg;

    // Decide which results this transaction produces
    assign has_text     = rec.char_val && (vtype_reg != VT_INT);
    assign has_done     = rec.line_end && !rec.end_code;
    assign has_err      = rec.eod_err;
    assign first_valid  = has_text || has_done || has_err;
    assign second_valid = has_text && has_done;

    always_comb
    begin
        text_res.kind  = RK_TEXT;
        text_res.tag   = tag_reg;
        text_res.vtype = vtype_reg;
        text_res.text  = rec.text;
        text_res.ival  = '0;
        text_res.last  = !has_done;

        done_res.kind  = RK_DONE;
        done_res.tag   = tag_reg;
        done_res.vtype = vtype_reg;
        done_res.text  = '0;
        done_res.ival  = (vtype_reg == VT_INT) ? rec.value : '0;
        done_res.last  = 1'b1;

        err_res.kind   = RK_ERROR;
        err_res.tag    = tag_eff;
        err_res.vtype  = vtype_eff;
        err_res.text   = '0;
        err_res.ival   = '0;
        err_res.last   = 1'b1;

        priority if (has_text)
        begin
            first_res = text_res;
        end
        else if (has_done)
        begin
            first_res = done_res;
        end
        else
        begin
            first_res = err_res;
        end
    end

    // Pop only when every result of the record has a place to go
    assign out_free = !out_valid_reg || result.ready;
    assign rec_pop  = rec_valid && !spill_valid_reg && (!first_valid || out_free);

    // Load the output register, drain the spill slot first
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        spill_valid_next = spill_valid_reg;
        spill_next       = spill_reg;
        tag_next         = tag_reg;
        vtype_next       = vtype_reg;
        if (spill_valid_reg)
        begin
            if (out_free)
            begin
                out_next         = spill_reg;
                out_valid_next   = 1'b1;
                spill_valid_next = 1'b0;
            end
        end
        else if (rec_pop && first_valid)
        begin
            out_next         = first_res;
            out_valid_next   = 1'b1;
            spill_valid_next = second_valid;
            spill_next       = done_res;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (rec_pop)
        begin
            if (do_cls)
            begin
                tag_next   = cls.tag;
                vtype_next = cls.vtype;
            end
            if (rec.eod)
            begin
                tag_next   = TAG_INVALID;
                vtype_next = VT_STRING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spill_valid_reg <= 1'b0;
            tag_reg         <= TAG_INVALID;
            vtype_reg       <= VT_STRING;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            spill_valid_reg <= spill_valid_next;
            tag_reg         <= tag_next;
            vtype_reg       <= vtype_next;
        end
    end

    // Hold result payloads
    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        spill_reg <= spill_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.result_kind   = out_reg.kind;
    assign result.tag_index     = out_reg.tag;
    assign result.value_type    = out_reg.vtype;
    assign result.text_byte_out = out_reg.text;
    assign result.int_value     = $signed(out_reg.ival);
    assign result.last          = out_reg.last;

    `DXFGCT_ASSERT_IMP(a_spill_needs_out, spill_valid_reg, out_valid_reg, "spill without output")
    `DXFGCT_ASSERT_IMP(a_no_pop_on_spill, spill_valid_reg, !rec_pop, "pop while spill pending")
    `DXFGCT_ASSERT_IMP(a_error_last, out_valid_reg && (out_reg.kind == RK_ERROR), out_reg.last, "error result not last")
    `DXFGCT_ASSERT_NXT(a_eod_clears_tag, rec_pop && rec.eod, tag_reg == TAG_INVALID, "tag kept after end of data")

endmodule

// ===== rtl/core/dxf_group_code_tokenizer.sv =====
`timescale 1ns / 1ps
// An accepted byte's record passes through the queue, and its first result is offered from the output register.
// Throughput: one byte per cycle while the queue is not full; a byte with two results
// (a value character that also ends the data) parks its second result in a spill slot.
// A 4-entry queue parts byte classification from result generation.
// Reset: rst_n clears line state, tag and queue; line_limit returns to 256.
module dxf_group_code_tokenizer (
    input  logic         clk,
    input  logic         rst_n,
    dxfgct_in_if.sink    text,
    dxfgct_cfg_if.sink   cfg,
    dxfgct_out_if.source result
);
    import dxfgct_pkg::*;

    logic        rec_push;
    dxfgct_rec_t push_rec;
    logic        queue_full;
    logic        rec_pop;
    logic        rec_valid;
    dxfgct_rec_t pop_rec;

    // Classify bytes and track lines
    dxfgct_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .cfg        (cfg),
        .queue_full (queue_full),
        .rec_push   (rec_push),
        .rec        (push_rec)
    );

    // Decouple front and back
    dxfgct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_rec  (push_rec),
        .full      (queue_full),
        .pop       (rec_pop),
        .pop_valid (rec_valid),
        .pop_rec   (pop_rec)
    );

    // Look up tags and issue results
    dxfgct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec       (pop_rec),
        .rec_pop   (rec_pop),
        .result    (result)
    );

endmodule
